>>> rtl/dasr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dasr_pkg;

  // field widths fixed by the readout format
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 17;
  localparam int FRAC_W      = 16;
  localparam int COUNT_CFG_W = 5;
  localparam int TAKEN_W     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int DIGIT_W     = 4;
  localparam int BCD_DIGITS  = 5;
  localparam int MAG_W       = 15;

  // largest count the sample_count register can hold
  localparam int CFG_COUNT_MAX = (1 << COUNT_CFG_W) - 1;

  // default sizing
  localparam int DEF_CHANNELS    = 2;
  localparam int DEF_MAX_AVERAGE = 16;

  // saturation level of the scaled magnitude
  localparam logic [MAG_W-1:0] MAG_LIMIT = 15'd32767;

  // register reset values
  localparam logic [COUNT_CFG_W-1:0] SAMPLE_COUNT_RST  = 5'd10;
  localparam logic [GAIN_W-1:0]      VOLT_GAIN_CH0_RST = 17'd70513;
  localparam logic [GAIN_W-1:0]      CURR_GAIN_CH0_RST = 17'd5132;
  localparam logic [GAIN_W-1:0]      VOLT_GAIN_CH1_RST = 17'd70073;
  localparam logic [GAIN_W-1:0]      CURR_GAIN_CH1_RST = 17'd5122;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT  = 3'd0,
    REG_VOLT_GAIN_CH0 = 3'd1,
    REG_CURR_GAIN_CH0 = 3'd2,
    REG_VOLT_GAIN_CH1 = 3'd3,
    REG_CURR_GAIN_CH1 = 3'd4
  } cfg_reg_t;

  // one sample request
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
    logic                       is_current;
  } in_item_t;

  // one reading
  typedef struct packed {
    logic               out_channel;
    logic               current_mode;
    logic               negative;
    logic [DIGIT_W-1:0] digit_ten_thousands;
    logic [DIGIT_W-1:0] digit_thousands;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_ones;
    logic               over_range;
  } out_item_t;

  typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

endpackage

`default_nettype wire

>>> rtl/dasr_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dasr_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> rtl/dasr_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module dasr_mul #(
  parameter int A_W = 20,
  parameter int B_W = dasr_pkg::GAIN_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic                  done,
  output logic [A_W+B_W-1:0]    prod
);

  localparam int CW = $clog2(B_W + 1);

  logic [A_W-1:0] a_r;
  logic [A_W-1:0] hi_r;
  logic [B_W-1:0] lo_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [A_W:0]   part_sum;

  // add the multiplicand when the low multiplier bit is set
  assign part_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      {hi_r, lo_r} <= {part_sum, lo_r[B_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

`default_nettype wire

>>> rtl/dasr_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dasr_div #(
  parameter int N_W = 21,
  parameter int D_W = 5
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [N_W-1:0]      quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic [D_W-1:0] d_r;
  logic [D_W-1:0] rem_r;
  logic [N_W-1:0] quo_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           fits;

  // restoring step: bring in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[N_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign fits  = (trial >= {1'b0, d_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
      quo_r <= {quo_r[N_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> rtl/dasr_bcd.sv
`timescale 1ns / 1ps
`default_nettype none

module dasr_bcd (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [dasr_pkg::MAG_W-1:0]   bin,
  output logic                              done,
  output dasr_pkg::bcd_t                    digits
);

  import dasr_pkg::*;

  localparam int CW = $clog2(MAG_W + 1);
  localparam logic [DIGIT_W-1:0] ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD = 4'd3;

  logic [MAG_W-1:0] bin_r;
  bcd_t             bcd_r;
  bcd_t             adj;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      adj[k] = (bcd_r[k] >= ADJ_MIN) ? bcd_r[k] + ADJ_ADD : bcd_r[k];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one binary bit into the digit shift register per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      {bcd_r, bin_r} <= {adj, bin_r} << 1;
    end
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule

`default_nettype wire

>>> rtl/dvm_average_scale_readout_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// in_req    in   valid/ready        sample, channel, is_current
// out_res   out  valid/ready        channel, mode, sign, five digits, over_range
// cfg_*     in   write enable only  cfg_index selects, cfg_wdata 17 bits
//
// samples that do not complete a reading are taken back to back; one that does
// starts a reading through the bit-serial multiplier, divider and decimal
// converter in turn, and no sample is taken until it reaches the output register
// synchronous active-low reset clears sums, counts and registers to defaults
// a finished reading waits in the output register, and samples are taken
// meanwhile; a second reading stalls in its last step until the first leaves

module dvm_average_scale_readout_unit #(
  parameter int CHANNELS    = dasr_pkg::DEF_CHANNELS,
  parameter int MAX_AVERAGE = dasr_pkg::DEF_MAX_AVERAGE
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dasr_stream_if.sink                          in_req,
  dasr_stream_if.source                        out_res,
  input  wire logic                            cfg_we,
  input  wire logic [dasr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dasr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import dasr_pkg::*;

  // sizing derived from the largest count that can be in effect
  localparam int MAXN    = (MAX_AVERAGE < CFG_COUNT_MAX) ? MAX_AVERAGE : CFG_COUNT_MAX;
  localparam int SUM_W   = SAMPLE_W + $clog2(MAXN);
  localparam int CNT_W   = $clog2(MAXN + 1);
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIV_N_W = SUM_W + GAIN_W - FRAC_W;
  localparam int LIM_W   = CNT_W + MAG_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_BCD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [COUNT_CFG_W-1:0] sample_count_r;
  logic [GAIN_W-1:0]      volt_gain_ch0_r;
  logic [GAIN_W-1:0]      curr_gain_ch0_r;
  logic [GAIN_W-1:0]      volt_gain_ch1_r;
  logic [GAIN_W-1:0]      curr_gain_ch1_r;

  // per-channel accumulators
  logic signed [SUM_W-1:0] sum_r   [CHANNELS];
  logic [TAKEN_W-1:0]      taken_r [CHANNELS];

  // reading in progress
  logic signed [SUM_W-1:0] work_sum_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [CNT_W-1:0]        n_r;
  logic                    ch_r;
  logic                    cur_r;
  logic                    ovr_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic                       in_take;
  logic                       ch_ok;
  logic [CH_W-1:0]            ch_idx;
  logic signed [SAMPLE_W-1:0] samp;
  logic signed [SUM_W-1:0]    sum_add;
  logic [TAKEN_W-1:0]         taken_add;
  logic [CNT_W-1:0]           n_eff;
  logic                       emit;
  logic [GAIN_W-1:0]          gain_sel;
  logic [SUM_W-1:0]           asum;
  logic [LIM_W-1:0]           ovr_limit;
  logic                       mul_start, mul_done;
  logic [SUM_W+GAIN_W-1:0]    mul_prod;
  logic                       div_start, div_done;
  logic [DIV_N_W-1:0]         div_quo;
  logic [MAG_W-1:0]           mag;
  logic                       bcd_start, bcd_done;
  bcd_t                       digits;
  logic                       out_load;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_take      = in_req.valid && in_req.ready;

  // samples for channels that are not built are dropped
  assign ch_ok  = (CHANNELS > 1) || (in_req.data.channel == 1'b0);
  assign ch_idx = CH_W'(in_req.data.channel);
  assign samp   = in_req.data.sample;

  // effective count, clamped to one and to the build maximum
  always_comb begin
    if (sample_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(sample_count_r) > MAX_AVERAGE) begin
      n_eff = CNT_W'(MAX_AVERAGE);
    end else begin
      n_eff = CNT_W'(sample_count_r);
    end
  end

  // accumulate and check for a complete reading
  assign sum_add   = sum_r[ch_idx] + SUM_W'(samp);
  assign taken_add = taken_r[ch_idx] + TAKEN_W'(1);
  assign emit      = (taken_add >= TAKEN_W'(n_eff));

  // gain by channel and mode of the last sample
  always_comb begin
    case ({in_req.data.channel, in_req.data.is_current})
      2'b00:   gain_sel = volt_gain_ch0_r;
      2'b01:   gain_sel = curr_gain_ch0_r;
      2'b10:   gain_sel = volt_gain_ch1_r;
      default: gain_sel = curr_gain_ch1_r;
    endcase
  end

  // magnitude of the sum and the over-range limit of 32767 times n
  assign asum      = work_sum_r[SUM_W-1] ? SUM_W'(-work_sum_r) : SUM_W'(work_sum_r);
  assign ovr_limit = {n_r, {MAG_W{1'b0}}} - LIM_W'(n_r);

  // clamp the scaled magnitude
  always_comb begin
    if (div_quo > DIV_N_W'(MAG_LIMIT)) begin
      mag = MAG_LIMIT;
    end else begin
      mag = div_quo[MAG_W-1:0];
    end
  end

  assign mul_start = (state_r == ST_PREP);
  assign div_start = (state_r == ST_MUL) && mul_done;
  assign bcd_start = (state_r == ST_DIV) && div_done;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_res.ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take && ch_ok && emit) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  if (mul_done) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_BCD;
      ST_BCD:  if (bcd_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= SAMPLE_COUNT_RST;
      volt_gain_ch0_r <= VOLT_GAIN_CH0_RST;
      curr_gain_ch0_r <= CURR_GAIN_CH0_RST;
      volt_gain_ch1_r <= VOLT_GAIN_CH1_RST;
      curr_gain_ch1_r <= CURR_GAIN_CH1_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_COUNT:  sample_count_r  <= cfg_wdata[COUNT_CFG_W-1:0];
        REG_VOLT_GAIN_CH0: volt_gain_ch0_r <= cfg_wdata[GAIN_W-1:0];
        REG_CURR_GAIN_CH0: curr_gain_ch0_r <= cfg_wdata[GAIN_W-1:0];
        REG_VOLT_GAIN_CH1: volt_gain_ch1_r <= cfg_wdata[GAIN_W-1:0];
        REG_CURR_GAIN_CH1: curr_gain_ch1_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // channel sums and counts, cleared when a reading starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        sum_r[k]   <= '0;
        taken_r[k] <= '0;
      end
    end else if (in_take && ch_ok) begin
      if (emit) begin
        sum_r[ch_idx]   <= '0;
        taken_r[ch_idx] <= '0;
      end else begin
        sum_r[ch_idx]   <= sum_add;
        taken_r[ch_idx] <= taken_add;
      end
    end
  end

  // capture the reading to be scaled
  always_ff @(posedge clk) begin
    if (in_take && ch_ok && emit) begin
      work_sum_r <= sum_add;
      gain_r     <= gain_sel;
      n_r        <= n_eff;
      ch_r       <= in_req.data.channel;
      cur_r      <= in_req.data.is_current;
    end
    if (mul_start) begin
      ovr_r <= (asum >= SUM_W'(ovr_limit));
    end
  end

  // |sum| times gain
  dasr_mul #(
    .A_W (SUM_W),
    .B_W (GAIN_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (asum),
    .b     (gain_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // drop the gain fraction, then divide by the count
  dasr_div #(
    .N_W (DIV_N_W),
    .D_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_prod[SUM_W+GAIN_W-1:FRAC_W]),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // decimal digits of the clamped magnitude
  dasr_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .bin    (mag),
    .done   (bcd_done),
    .digits (digits)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_channel         <= ch_r;
      out_data_r.current_mode        <= cur_r;
      out_data_r.negative            <= work_sum_r[SUM_W-1] && (mag != '0);
      out_data_r.digit_ten_thousands <= cur_r ? '0 : digits[4];
      out_data_r.digit_thousands     <= digits[3];
      out_data_r.digit_hundreds      <= digits[2];
      out_data_r.digit_tens          <= digits[1];
      out_data_r.digit_ones          <= digits[0];
      out_data_r.over_range          <= ovr_r;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

endmodule

`default_nettype wire
